### hdl/peer_piece_selector_defines.svh
// Assertion macros shared by the peer piece selector RTL.
// Depends on nothing; included by the top level only.
`ifndef PEER_PIECE_SELECTOR_DEFINES_SVH
`define PEER_PIECE_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("peer_piece_selector: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("peer_piece_selector: next-cycle check failed");

`endif

### hdl/pps_pkg.sv
// Shared types, constants and helper functions of the peer piece selector.
// Depends on nothing; used by every other module.
`timescale 1ns / 1ps

package pps_pkg;

    // Field and register widths.
    localparam int PIECE_W  = 12;
    localparam int BYTE_W   = 9;
    localparam int VALUE_W  = 8;
    localparam int COUNT_W  = 13;
    localparam int SEED_W   = 32;
    localparam int NBYTES_W = 11;

    localparam int unsigned     DEF_MAX_PIECES = 4096;
    localparam logic [12:0]     COUNT_RESET    = 13'd4096;
    localparam logic [31:0]     SEED_RESET     = 32'd1;
    localparam logic [31:0]     LFSR_TAPS      = 32'h8020_0003;

    // Configuration register indexes.
    localparam logic CFG_PIECE_COUNT = 1'b0;
    localparam logic CFG_RANDOM_SEED = 1'b1;

    typedef enum logic [2:0] {
        OP_CHOKE      = 3'd0,
        OP_UNCHOKE    = 3'd1,
        OP_PEER_HAVE  = 3'd2,
        OP_BITFIELD   = 3'd3,
        OP_LOCAL_HAVE = 3'd4,
        OP_PICK       = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    // One classified operation waiting in the queue.
    typedef struct packed {
        op_t                 op;
        logic [PIECE_W-1:0]  piece_index;
        logic [BYTE_W-1:0]   byte_index;
        logic [VALUE_W-1:0]  byte_value;
        logic                bad;
    } q_entry_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RMW,
        ST_CLEAR,
        ST_PSCAN_ADDR,
        ST_PSCAN_DATA,
        ST_PBIT,
        ST_PDIV,
        ST_TAIL,
        ST_ISCAN_ADDR,
        ST_ISCAN_DATA,
        ST_DONE
    } back_state_t;

    // Piece count limited to the bitmap size.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c,
                                                     input int unsigned maxp);
        if (32'(c) > maxp)
            return COUNT_W'(maxp);
        return c;
    endfunction

    // Number of bitmap bytes that hold valid pieces.
    function automatic logic [NBYTES_W-1:0] nbytes_of(input logic [COUNT_W-1:0] c);
        logic [COUNT_W:0] sum;
        sum = {1'b0, c} + (COUNT_W+1)'(7);
        return NBYTES_W'(sum >> 3);
    endfunction

    // Bits of a bitmap byte that belong to valid pieces, MSB first.
    function automatic logic [7:0] valid_mask(input logic [NBYTES_W-1:0] idx,
                                              input logic [COUNT_W-1:0] c);
        logic [COUNT_W:0] first;
        logic [COUNT_W:0] n;
        first = {idx, 3'b000};
        n     = {1'b0, c} - first;
        if (first >= {1'b0, c})
            return 8'h00;
        if (n >= (COUNT_W+1)'(8))
            return 8'hFF;
        return 8'hFF << (4'd8 - {1'b0, n[2:0]});
    endfunction

    // Bit of a piece within its byte.
    function automatic logic [7:0] piece_bit(input logic [2:0] b);
        return 8'h80 >> b;
    endfunction

    // One step of the Galois LFSR.
    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

### hdl/pps_front.sv
// Front end: accepts operations, checks index ranges and queues them.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_front #(
    parameter int unsigned MAX_PIECES = pps_pkg::DEF_MAX_PIECES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pps_pkg::COUNT_W-1:0]   count,
    input  logic                          init_busy,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_opcode,
    input  logic [pps_pkg::PIECE_W-1:0]   s_piece_index,
    input  logic [pps_pkg::BYTE_W-1:0]    s_byte_index,
    input  logic [pps_pkg::VALUE_W-1:0]   s_byte_value,
    output logic                          q_valid,
    output pps_pkg::q_entry_t             q_data,
    input  logic                          q_pop
);
    import pps_pkg::*;

    q_entry_t                ent_reg [2];
    logic                    wr_ptr_reg, wr_ptr_next;
    logic                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [COUNT_W-1:0]      eff;
    logic [NBYTES_W-1:0]     nbytes;
    q_entry_t                new_ent;
    logic                    push;

    // Classify the incoming operation.
    always_comb begin
        eff                 = eff_count(count, MAX_PIECES);
        nbytes              = nbytes_of(eff);
        new_ent.op          = op_t'(s_opcode);
        new_ent.piece_index = s_piece_index;
        new_ent.byte_index  = s_byte_index;
        new_ent.byte_value  = s_byte_value;
        case (op_t'(s_opcode))
            OP_PEER_HAVE, OP_LOCAL_HAVE: new_ent.bad = {1'b0, s_piece_index} >= eff;
            OP_BITFIELD:                 new_ent.bad = {2'b00, s_byte_index} >= nbytes;
            default:                     new_ent.bad = 1'b0;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2) && !init_busy;
    assign push    = s_valid && s_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = ent_reg[rd_ptr_reg];

    // Queue pointers.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push)
            ent_reg[wr_ptr_reg] <= new_ent;
    end

endmodule

### hdl/pps_mod.sv
// Iterative remainder unit: tells whether a 32-bit value is a multiple of k.
// Depends on pps_pkg; one quotient bit per cycle; a new start abandons any request in progress.
`timescale 1ns / 1ps

module pps_mod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pps_pkg::SEED_W-1:0]   dividend,
    input  logic [pps_pkg::COUNT_W-1:0]  divisor,
    output logic                         done,
    output logic                         rem_zero
);
    import pps_pkg::*;

    localparam int DIV_STEPS = SEED_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SEED_W-1:0]   num_reg, num_next;
    logic [COUNT_W-1:0]  den_reg, den_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W:0]    trial;

    // One restoring step: shift in the next bit and subtract when it fits.
    always_comb begin
        trial     = {rem_reg, num_reg[SEED_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (trial >= {1'b0, den_reg})
                rem_next = COUNT_W'(trial - {1'b0, den_reg});
            else
                rem_next = trial[COUNT_W-1:0];
            if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = rem_reg == '0;

endmodule

### hdl/pps_back.sv
// Back end: holds both piece bitmaps, executes queued operations, runs picks.
// Depends on pps_pkg and pps_mod.
`timescale 1ns / 1ps

module pps_back #(
    parameter int unsigned MAX_PIECES = pps_pkg::DEF_MAX_PIECES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pps_pkg::COUNT_W-1:0]   count,
    input  logic [pps_pkg::SEED_W-1:0]    seed,
    input  logic                          count_wr,
    input  logic                          q_valid,
    input  pps_pkg::q_entry_t             q_data,
    output logic                          q_pop,
    output logic                          init_busy,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic                          m_pick_valid,
    output logic [pps_pkg::PIECE_W-1:0]   m_picked_piece,
    output logic                          m_interested,
    output logic                          m_status
);
    import pps_pkg::*;

    localparam int MAP_BYTES = (MAX_PIECES + 7) / 8;
    localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    back_state_t          state_reg, state_next;
    q_entry_t             entry_reg, entry_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [NBYTES_W-1:0]  idx_reg, idx_next;
    logic [7:0]           cand_reg, cand_next;
    logic [COUNT_W-1:0]   k_reg, k_next;
    logic [2:0]           cur_b_reg, cur_b_next;
    logic [PIECE_W-1:0]   choice_reg, choice_next;
    logic                 found_reg, found_next;
    logic [SEED_W-1:0]    lfsr_reg, lfsr_next_val;
    logic                 choking_reg, choking_next;
    logic                 want_reg, want_next;
    logic                 dirty_reg, dirty_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 pick_valid_reg, pick_valid_next;
    logic [PIECE_W-1:0]   piece_reg, piece_next;
    logic                 interested_reg, interested_next;
    logic                 status_reg, status_next;

    logic [7:0]           peer_ram_reg  [MAP_BYTES];
    logic [7:0]           local_ram_reg [MAP_BYTES];
    logic [7:0]           peer_rd_reg, local_rd_reg;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic                 peer_we, local_we;
    logic [7:0]           peer_wdata, local_wdata;

    logic [COUNT_W-1:0]   eff;
    logic [NBYTES_W-1:0]  nbytes;
    logic [NBYTES_W-1:0]  idx_inc;
    logic [7:0]           scan_cand;
    logic [7:0]           bmask;
    logic [2:0]           lead_b;
    logic [SEED_W-1:0]    lfsr_stepped;
    logic                 last_clr;
    logic                 out_free;
    logic                 div_start, div_done, div_zero;

    // Shared decode of the current scan and entry.
    always_comb begin
        eff          = eff_count(count, MAX_PIECES);
        nbytes       = nbytes_of(eff);
        idx_inc      = idx_reg + NBYTES_W'(1);
        scan_cand    = peer_rd_reg & ~local_rd_reg & valid_mask(idx_reg, eff);
        bmask        = piece_bit(entry_reg.piece_index[2:0]);
        lfsr_stepped = lfsr_next(lfsr_reg);
        last_clr     = clr_reg == AW'(MAP_BYTES - 1);
        out_free     = !m_valid_reg || m_ready;
        lead_b       = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (cand_reg[i])
                lead_b = 3'(7 - i);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (last_clr)
                    state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_data.bad) begin
                        state_next = ST_TAIL;
                    end else begin
                        case (q_data.op)
                            OP_PEER_HAVE, OP_LOCAL_HAVE, OP_BITFIELD: state_next = ST_RMW;
                            OP_PICK: state_next = (!choking_reg && want_reg) ?
                                                  ST_PSCAN_ADDR : ST_TAIL;
                            OP_CLEAR: state_next = ST_CLEAR;
                            default: state_next = ST_TAIL;
                        endcase
                    end
                end
            end
            ST_RMW:   state_next = ST_TAIL;
            ST_CLEAR: begin
                if (last_clr)
                    state_next = ST_DONE;
            end
            ST_PSCAN_ADDR: state_next = (idx_reg >= nbytes) ? ST_TAIL : ST_PSCAN_DATA;
            ST_PSCAN_DATA: begin
                if (scan_cand != 8'h00)
                    state_next = ST_PBIT;
                else if (idx_inc >= nbytes)
                    state_next = ST_TAIL;
            end
            ST_PBIT: state_next = (cand_reg == 8'h00) ? ST_PSCAN_ADDR : ST_PDIV;
            ST_PDIV: begin
                if (div_done)
                    state_next = ST_PBIT;
            end
            ST_TAIL: state_next = (dirty_reg && !want_reg) ? ST_ISCAN_ADDR : ST_DONE;
            ST_ISCAN_ADDR: state_next = (idx_reg >= nbytes) ? ST_DONE : ST_ISCAN_DATA;
            ST_ISCAN_DATA: begin
                if (scan_cand != 8'h00 || idx_inc >= nbytes)
                    state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result register.
    always_comb begin
        entry_next      = entry_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        cand_next       = cand_reg;
        k_next          = k_reg;
        cur_b_next      = cur_b_reg;
        choice_next     = choice_reg;
        found_next      = found_reg;
        lfsr_next_val   = lfsr_reg;
        choking_next    = choking_reg;
        want_next       = want_reg;
        dirty_next      = dirty_reg || count_wr;
        m_valid_next    = m_valid_reg && !m_ready;
        pick_valid_next = pick_valid_reg;
        piece_next      = piece_reg;
        interested_next = interested_reg;
        status_next     = status_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        rd_addr         = AW'(idx_reg);
        peer_we         = 1'b0;
        local_we        = 1'b0;
        peer_wdata      = 8'h00;
        local_wdata     = 8'h00;
        if (entry_reg.op == OP_BITFIELD)
            wr_addr = AW'(entry_reg.byte_index);
        else
            wr_addr = AW'(entry_reg.piece_index[PIECE_W-1:3]);
        case (state_reg)
            ST_INIT: begin
                wr_addr  = clr_reg;
                peer_we  = 1'b1;
                local_we = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE: begin
                if (q_data.op == OP_BITFIELD)
                    rd_addr = AW'(q_data.byte_index);
                else
                    rd_addr = AW'(q_data.piece_index[PIECE_W-1:3]);
                if (q_valid) begin
                    q_pop       = 1'b1;
                    entry_next  = q_data;
                    idx_next    = '0;
                    k_next      = '0;
                    found_next  = 1'b0;
                    choice_next = '0;
                    clr_next    = '0;
                    if (q_data.op == OP_CHOKE)
                        choking_next = 1'b1;
                    if (q_data.op == OP_UNCHOKE)
                        choking_next = 1'b0;
                    if (q_data.op == OP_CLEAR) begin
                        choking_next  = 1'b1;
                        want_next     = 1'b0;
                        dirty_next    = 1'b0;
                        lfsr_next_val = seed;
                    end
                end
            end
            ST_RMW: begin
                case (entry_reg.op)
                    OP_PEER_HAVE: begin
                        peer_we    = 1'b1;
                        peer_wdata = peer_rd_reg | bmask;
                        if ((bmask & ~local_rd_reg) != 8'h00)
                            want_next = 1'b1;
                    end
                    OP_BITFIELD: begin
                        peer_we    = 1'b1;
                        peer_wdata = entry_reg.byte_value;
                        if ((entry_reg.byte_value & ~local_rd_reg &
                             valid_mask(NBYTES_W'(entry_reg.byte_index), eff)) != 8'h00)
                            want_next = 1'b1;
                    end
                    OP_LOCAL_HAVE: begin
                        local_we    = 1'b1;
                        local_wdata = local_rd_reg | bmask;
                    end
                    default: ;
                endcase
            end
            ST_CLEAR: begin
                wr_addr  = clr_reg;
                peer_we  = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            ST_PSCAN_DATA, ST_ISCAN_DATA: begin
                if (scan_cand != 8'h00) begin
                    cand_next = scan_cand;
                    if (state_reg == ST_ISCAN_DATA)
                        want_next = 1'b1;
                end else if (idx_inc < nbytes) begin
                    idx_next = idx_inc;
                    rd_addr  = AW'(idx_inc);
                end
            end
            ST_PBIT: begin
                if (cand_reg == 8'h00) begin
                    idx_next = idx_inc;
                end else begin
                    cand_next     = cand_reg & ~piece_bit(lead_b);
                    cur_b_next    = lead_b;
                    lfsr_next_val = lfsr_stepped;
                    k_next        = k_reg + COUNT_W'(1);
                    div_start     = 1'b1;
                end
            end
            ST_PDIV: begin
                if (div_done && div_zero) begin
                    choice_next = {idx_reg[PIECE_W-4:0], cur_b_reg};
                    found_next  = 1'b1;
                end
            end
            ST_TAIL: begin
                dirty_next = count_wr;
                idx_next   = '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    pick_valid_next = found_reg;
                    piece_next      = found_reg ? choice_reg : '0;
                    interested_next = want_reg;
                    status_next     = entry_reg.bad;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            clr_reg     <= '0;
            found_reg   <= 1'b0;
            lfsr_reg    <= SEED_RESET;
            choking_reg <= 1'b1;
            want_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            found_reg   <= found_next;
            lfsr_reg    <= lfsr_next_val;
            choking_reg <= choking_next;
            want_reg    <= want_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg      <= entry_next;
        idx_reg        <= idx_next;
        cand_reg       <= cand_next;
        k_reg          <= k_next;
        cur_b_reg      <= cur_b_next;
        choice_reg     <= choice_next;
        pick_valid_reg <= pick_valid_next;
        piece_reg      <= piece_next;
        interested_reg <= interested_next;
        status_reg     <= status_next;
    end

    // Bitmap memories: one write port, one registered read port each.
    always_ff @(posedge aclk) begin
        if (peer_we)
            peer_ram_reg[wr_addr] <= peer_wdata;
        peer_rd_reg <= peer_ram_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (local_we)
            local_ram_reg[wr_addr] <= local_wdata;
        local_rd_reg <= local_ram_reg[rd_addr];
    end

    // Reservoir test: the new candidate wins when the LFSR is a multiple of k.
    pps_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lfsr_stepped),
        .divisor  (k_reg + COUNT_W'(1)),
        .done     (div_done),
        .rem_zero (div_zero)
    );

    assign init_busy      = state_reg == ST_INIT;
    assign m_valid        = m_valid_reg;
    assign m_pick_valid   = pick_valid_reg;
    assign m_picked_piece = piece_reg;
    assign m_interested   = interested_reg;
    assign m_status       = status_reg;

endmodule

### hdl/peer_piece_selector.sv
// Peer piece selector top level: configuration registers, front end and back end.
// Depends on pps_pkg, pps_front, pps_back and peer_piece_selector_defines.svh.
//
// Every operation gives exactly one result transfer. After reset the block zeroes
// all (MAX_PIECES+7)/8 bytes (512 at the default size) of both bitmap memories,
// with s_ready low. Choke, unchoke and the unused opcode go from idle straight to
// the tail state; the indexed updates first do one read-modify-write of a bitmap
// byte. A pick scans the bitmap bytes and, for each candidate piece, runs the
// remainder unit of the reservoir test. Clear sweeps all (MAX_PIECES+7)/8 bytes of
// the peer bitmap. The first operation after a piece_count write may rescan up to
// ceil(count/8) bytes to refresh interest. A two-entry queue lets new operations be
// taken while the back end works.
`timescale 1ns / 1ps
`include "peer_piece_selector_defines.svh"

module peer_piece_selector #(
    parameter int unsigned MAX_PIECES = pps_pkg::DEF_MAX_PIECES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [pps_pkg::SEED_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_opcode,
    input  logic [pps_pkg::PIECE_W-1:0]   s_piece_index,
    input  logic [pps_pkg::BYTE_W-1:0]    s_byte_index,
    input  logic [pps_pkg::VALUE_W-1:0]   s_byte_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pick_valid,
    output logic [pps_pkg::PIECE_W-1:0]   m_picked_piece,
    output logic                          m_interested,
    output logic                          m_status
);
    import pps_pkg::*;

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SEED_W-1:0]   seed_reg, seed_next;
    logic                count_wr;
    logic                init_busy;
    logic                q_valid, q_pop;
    q_entry_t            q_data;

    // Configuration registers.
    always_comb begin
        count_wr   = cfg_wr_en && (cfg_index == CFG_PIECE_COUNT);
        count_next = count_wr ? cfg_wr_data[COUNT_W-1:0] : count_reg;
        seed_next  = (cfg_wr_en && (cfg_index == CFG_RANDOM_SEED)) ? cfg_wr_data : seed_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
            seed_reg  <= SEED_RESET;
        end else begin
            count_reg <= count_next;
            seed_reg  <= seed_next;
        end
    end

    pps_front #(
        .MAX_PIECES (MAX_PIECES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .count         (count_reg),
        .init_busy     (init_busy),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_piece_index (s_piece_index),
        .s_byte_index  (s_byte_index),
        .s_byte_value  (s_byte_value),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop)
    );

    pps_back #(
        .MAX_PIECES (MAX_PIECES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .count          (count_reg),
        .seed           (seed_reg),
        .count_wr       (count_wr),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .init_busy      (init_busy),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_pick_valid   (m_pick_valid),
        .m_picked_piece (m_picked_piece),
        .m_interested   (m_interested),
        .m_status       (m_status)
    );

    // A result without a pick carries piece zero.
    `PPS_ASSERT_IMP(a_no_pick_zero, aclk, aresetn, m_valid && !m_pick_valid, m_picked_piece == '0)
    // A pick only happens once interest is set.
    `PPS_ASSERT_IMP(a_pick_interest, aclk, aresetn, m_valid && m_pick_valid, m_interested)
    // An ignored operation never yields a pick.
    `PPS_ASSERT_IMP(a_bad_no_pick, aclk, aresetn, m_valid && m_status, !m_pick_valid)
    // A piece_count write lands in the register.
    `PPS_ASSERT_NXT(a_count_write, aclk, aresetn, count_wr, count_reg == $past(cfg_wr_data[COUNT_W-1:0]))

endmodule
